FILE: hw/rtl/csv_fs_pkg.sv
`default_nettype none
package csv_fs_pkg;

    typedef enum logic [4:0] {
        ST_START  = 5'b00001,
        ST_TOKEN  = 5'b00010,
        ST_COMMA  = 5'b00100,
        ST_STRING = 5'b01000,
        ST_QUOTED = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        K_DATA  = 3'd0,
        K_FIELD = 3'd1,
        K_LINE  = 3'd2,
        K_EMPTY = 3'd3,
        K_EOFLS = 3'd4
    } kind_t;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] field_byte;
        logic       input_ended;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
        state_t  next_state;
    } decode_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csv_fs_decode.sv
`default_nettype none
module csv_fs_decode
    import csv_fs_pkg::*;
(
    input  var state_t     state,
    input  wire [7:0]      byte_in,
    input  wire            end_of_input,
    output decode_t        dec
);

    logic is_blank;

    assign is_blank = (byte_in == CH_SP) || (byte_in == CH_TAB);

    always_comb
    begin
        dec.emit                = 1'b0;
        dec.res.kind            = K_DATA;
        dec.res.field_byte      = 8'd0;
        dec.res.input_ended     = 1'b0;
        dec.next_state          = state;

        unique case (state)
            ST_TOKEN, ST_COMMA, ST_STRING, ST_QUOTED:
            begin
                // end of input or newline closes field and line in every non-start state
                if (end_of_input)
                begin
                    dec.emit            = 1'b1;
                    dec.res.kind        = K_LINE;
                    dec.res.input_ended = 1'b1;
                    dec.next_state      = ST_START;
                end
                else if (byte_in == CH_LF)
                begin
                    dec.emit       = 1'b1;
                    dec.res.kind   = K_LINE;
                    dec.next_state = ST_START;
                end
                else if (byte_in == CH_CR)
                begin
                    dec.emit = 1'b0;
                end
                else if (state == ST_STRING)
                begin
                    if (byte_in == CH_QUOTE)
                        dec.next_state = ST_QUOTED;
                    else
                    begin
                        dec.emit           = 1'b1;
                        dec.res.field_byte = byte_in;
                    end
                end
                else if (byte_in == CH_COMMA)
                begin
                    dec.emit       = 1'b1;
                    dec.res.kind   = K_FIELD;
                    dec.next_state = ST_COMMA;
                end
                else if (byte_in == CH_QUOTE)
                begin
                    // doubled quote after a closing quote is one literal quote
                    dec.next_state = ST_STRING;
                    if (state == ST_QUOTED)
                    begin
                        dec.emit           = 1'b1;
                        dec.res.field_byte = byte_in;
                    end
                end
                else if ((state == ST_COMMA) && is_blank)
                begin
                    dec.emit = 1'b0;
                end
                else
                begin
                    dec.emit           = 1'b1;
                    dec.res.field_byte = byte_in;
                    dec.next_state     = ST_TOKEN;
                end
            end
            default:
            begin
                // line start, also taken for codes that cannot arise
                dec.next_state = ST_START;
                if (end_of_input)
                begin
                    dec.emit            = 1'b1;
                    dec.res.kind        = K_EOFLS;
                    dec.res.input_ended = 1'b1;
                end
                else if ((byte_in == CH_CR) || is_blank)
                begin
                    dec.emit = 1'b0;
                end
                else if (byte_in == CH_LF)
                begin
                    dec.emit     = 1'b1;
                    dec.res.kind = K_EMPTY;
                end
                else if (byte_in == CH_COMMA)
                begin
                    dec.emit       = 1'b1;
                    dec.res.kind   = K_FIELD;
                    dec.next_state = ST_COMMA;
                end
                else if (byte_in == CH_QUOTE)
                begin
                    dec.next_state = ST_STRING;
                end
                else
                begin
                    dec.emit           = 1'b1;
                    dec.res.field_byte = byte_in;
                    dec.next_state     = ST_TOKEN;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csv_fs_out_reg.sv
`default_nettype none
module csv_fs_out_reg
    import csv_fs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        load,
    input  var result_t res_in,
    output logic       room,
    output logic       valid,
    input  wire        ready,
    output result_t    res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // register can take a new result when empty or being drained this cycle
    assign room       = !valid_reg || ready;
    assign valid_next = load || (valid_reg && !ready);
    assign valid      = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csv_field_splitter_unit.sv
`default_nettype none
// Streaming splitter for comma-separated lines with quoted fields. Each input
// transfer carries one character, or an end-of-input event in tuser, and gives
// at most one output transfer: a field byte or a field, line, empty-line or
// end-at-line-start marker. One character is taken every clock cycle unless the
// output register is full and the character needs it; the parse state register,
// updated by the decode step once per character, sets this rate. A character is
// registered at the input and its result at the output. Skipped characters (CR,
// leading blanks, quotes that open or close a field) make no output transfer.
module csv_field_splitter_unit
    import csv_fs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // byte_in
    input  wire        s_axis_tuser,   // end_of_input
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // field_byte
    output logic [3:0] m_axis_tuser    // kind[2:0], input_ended[3]
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    state_t     state_reg;
    state_t     state_next;
    decode_t    dec;
    logic       out_room;
    logic       advance;
    logic       load;
    logic       s_accept;
    result_t    res_out;

    csv_fs_decode u_decode (
        .state        (state_reg),
        .byte_in      (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .dec          (dec)
    );

    // an item with no result leaves the input stage even when the output is full
    assign advance       = in_valid_reg && (!dec.emit || out_room);
    assign load          = advance && dec.emit;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);
    assign state_next    = advance ? dec.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_START;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    csv_fs_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .res_in  (dec.res),
        .room    (out_room),
        .valid   (m_axis_tvalid),
        .ready   (m_axis_tready),
        .res_out (res_out)
    );

    assign m_axis_tdata = res_out.field_byte;
    assign m_axis_tuser = {res_out.input_ended, res_out.kind};

    a_eoi_returns_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eoi_reg |=> state_reg == ST_START)
        else $error("end of input did not return to line start");

    a_eoi_marks_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eoi_reg |=> m_axis_tvalid && m_axis_tuser[3])
        else $error("end of input gave no ended marker");

    a_data_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == K_DATA) |-> !m_axis_tuser[3])
        else $error("data byte flagged as input ended");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !m_axis_tvalid || m_axis_tready)
        else $error("result loaded over a pending transfer");

endmodule
`default_nettype wire
